@@ hdl/pdee_pkg.sv @@
package pdee_pkg;

  localparam int DATA_W      = 32;
  localparam int SYM_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int QUEUE_DEPTH = 2;

  // ASCII codes of the accepted characters
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd4;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BAD
  } op_t;

  // Classified character as it travels from front to back
  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

endpackage

@@ hdl/pdee_front.sv @@
module pdee_front
  import pdee_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_last,
  output logic             push_valid,
  input  logic             push_ready,
  output cmd_t             push_cmd
);

  logic fr_valid_r;
  logic fr_valid_nxt;
  cmd_t fr_cmd_r;
  cmd_t cls_cmd;
  logic in_xfer;

  // Classify the incoming character
  always_comb begin
    cls_cmd.last  = in_last;
    cls_cmd.digit = 4'(in_symbol - CH_ZERO);
    case (in_symbol) inside
      [CH_ZERO:CH_NINE]: cls_cmd.op = OP_DIGIT;
      CH_PLUS:           cls_cmd.op = OP_ADD;
      CH_MINUS:          cls_cmd.op = OP_SUB;
      CH_STAR:           cls_cmd.op = OP_MUL;
      CH_SLASH:          cls_cmd.op = OP_DIV;
      default:           cls_cmd.op = OP_BAD;
    endcase
  end

  assign in_ready   = !fr_valid_r || push_ready;
  assign in_xfer    = in_valid && in_ready;
  assign push_valid = fr_valid_r;
  assign push_cmd   = fr_cmd_r;

  // Hold the classified item until the queue takes it
  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (in_xfer) begin
      fr_valid_nxt = 1'b1;
    end else if (push_ready) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fr_cmd_r <= cls_cmd;
    end
  end

endmodule

@@ hdl/pdee_queue.sv @@
module pdee_queue
  import pdee_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          data_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push;
  logic          pop;

  assign push_ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = data_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ hdl/pdee_divider.sv @@
module pdee_divider
  import pdee_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] dividend,
  input  logic signed [DATA_W-1:0] divisor,
  output logic                     done,
  output logic        [DATA_W-1:0] quotient
);

  localparam int NW = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [NW-1:0]     cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic              neg_r;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] a_mag;
  logic [DATA_W-1:0] b_mag;

  assign a_mag   = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
  assign b_mag   = divisor[DATA_W-1]  ? DATA_W'(-divisor)  : DATA_W'(divisor);
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  assign done     = done_r;
  assign quotient = neg_r ? DATA_W'(-quo_r) : quo_r;

  // One restoring step per cycle on the magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + NW'(1);
        if (cnt_r == NW'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= a_mag;
      dvs_r <= b_mag;
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_r <= diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ hdl/pdee_back.sv @@
module pdee_back
  import pdee_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  cmd_t                       pop_cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   out_value,
  output logic        [STATUS_W-1:0] out_status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_FETCH = 5'b00001,
    S_EXEC  = 5'b00010,
    S_DIV   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_SPARE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic [DATA_W-1:0]   top_r, top_nxt;
  logic [DATA_W-1:0]   mem [STACK_DEPTH];
  logic [DATA_W-1:0]   rdata_r;
  logic [CW-1:0]       cnt_m1;
  logic [CW-1:0]       cnt_m2;
  logic                mem_we;
  logic                div_start;
  logic                div_done;
  logic [DATA_W-1:0]   div_quo;
  logic                out_load;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_value_r;
  logic [STATUS_W-1:0] out_status_r;
  state_t              after_cmd;

  assign cnt_m1    = count_r - CW'(1);
  assign cnt_m2    = count_r - CW'(2);
  assign pop_ready = (state_r == S_FETCH);
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign after_cmd = cmd_r.last ? S_EMIT : S_FETCH;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  pdee_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rdata_r),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Stack sequencer: top of stack in a register, the rest in memory
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    top_nxt   = top_r;
    mem_we    = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_FETCH: begin
        if (pop_valid) begin
          state_nxt = pop_cmd.last ? S_EMIT : S_FETCH;
          if (err_r == ST_OK) begin
            case (pop_cmd.op)
              OP_DIGIT: begin
                if (count_r >= CW'(STACK_DEPTH)) begin
                  err_nxt = ST_OVERFLOW;
                end else begin
                  mem_we    = (count_r != '0);
                  top_nxt   = DATA_W'(pop_cmd.digit);
                  count_nxt = count_r + CW'(1);
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (count_r < CW'(2)) begin
                  err_nxt = ST_UNDERFLOW;
                end else begin
                  state_nxt = S_EXEC;
                end
              end
              default: err_nxt = ST_UNKNOWN;
            endcase
          end
        end
      end
      S_EXEC: begin
        state_nxt = after_cmd;
        case (cmd_r.op)
          OP_ADD: begin
            top_nxt   = rdata_r + top_r;
            count_nxt = cnt_m1;
          end
          OP_SUB: begin
            top_nxt   = rdata_r - top_r;
            count_nxt = cnt_m1;
          end
          OP_MUL: begin
            top_nxt   = DATA_W'(rdata_r * top_r);
            count_nxt = cnt_m1;
          end
          default: begin
            if (top_r == '0) begin
              err_nxt = ST_DIVZERO;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          top_nxt   = div_quo;
          count_nxt = cnt_m1;
          state_nxt = after_cmd;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          count_nxt = '0;
          err_nxt   = ST_OK;
          state_nxt = S_FETCH;
        end
      end
      default: state_nxt = S_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FETCH;
      count_r <= '0;
      err_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  // Latch the command and top of stack
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (state_r == S_FETCH && pop_valid) begin
      cmd_r <= pop_cmd;
    end
  end

  // Spill old top on push; fetch left operand every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_m1[AW-1:0]] <= top_r;
    end
    rdata_r <= mem[cnt_m2[AW-1:0]];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (err_r != ST_OK) begin
        out_status_r <= err_r;
        out_value_r  <= '0;
      end else if (count_r == '0) begin
        out_status_r <= ST_UNDERFLOW;
        out_value_r  <= '0;
      end else begin
        out_status_r <= ST_OK;
        out_value_r  <= top_r;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (count_r == '0) && (err_r == ST_OK) && out_valid_r)
    else $error("stack not cleared after result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_value_r == '0))
    else $error("nonzero value with error status");

endmodule

@@ hdl/postfix_digit_expression_evaluator.sv @@
// A character is registered in the front, passes the queue and is then taken by the
// stack sequencer in S_FETCH; + - * go on through S_EXEC, / through S_EXEC and S_DIV
// (32-step iterative divider). A last character then passes S_EMIT to register the
// result. Digits and unknown characters are taken one per cycle while the sequencer
// stays in S_FETCH; operators and the output stall hold the flow. Reset (rst_n low,
// synchronous): empties queue and stack, clears the error.
module postfix_digit_expression_evaluator
  import pdee_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic        [SYM_W-1:0]    in_symbol,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   out_value,
  output logic        [STATUS_W-1:0] out_status
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  pdee_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_symbol  (in_symbol),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  pdee_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  pdee_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import pdee_pkg::*;

  localparam int MAX_DEPTH     = 16;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int N_DIRECTED    = 26;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [SYM_W-1:0]    sym;
    logic                last;
    logic                typed;
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } row_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;
  } result_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic        [SYM_W-1:0]    in_symbol  = '0;
  logic                       in_last    = 1'b0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic signed [DATA_W-1:0]   out_value;
  logic        [STATUS_W-1:0] out_status;

  // Operand stack and sticky error as the evaluator should hold them
  logic signed [DATA_W-1:0] operands [MAX_DEPTH];
  int unsigned              operand_count = 0;
  logic [STATUS_W-1:0]      pending_error = ST_OK;

  result_t          pending_results [$];
  logic [SYM_W-1:0] expr_syms [$];
  int               mismatches    = 0;
  int               symbols_sent  = 0;
  bit               source_calm   = 1'b0;
  int               sink_hold     = 0;

  // Directed expressions: typed results only where they are obvious
  row_t directed_rows [N_DIRECTED] = '{
    '{"7",      1'b1, 1'b1, 32'd7, ST_OK},
    '{"0",      1'b1, 1'b1, 32'd0, ST_OK},
    '{CH_PLUS,  1'b1, 1'b1, 32'd0, ST_UNDERFLOW},
    '{8'h00,    1'b1, 1'b1, 32'd0, ST_UNKNOWN},
    '{8'hFF,    1'b1, 1'b1, 32'd0, ST_UNKNOWN},
    '{"9",      1'b0, 1'b0, 32'd0, ST_OK},
    '{"0",      1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_SLASH, 1'b1, 1'b1, 32'd0, ST_DIVZERO},
    '{"9",      1'b0, 1'b0, 32'd0, ST_OK},
    '{"3",      1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_MINUS, 1'b1, 1'b0, 32'd0, ST_OK},
    '{"8",      1'b0, 1'b0, 32'd0, ST_OK},
    '{"7",      1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_STAR,  1'b0, 1'b0, 32'd0, ST_OK},
    '{"5",      1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_PLUS,  1'b0, 1'b0, 32'd0, ST_OK},
    '{"2",      1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_SLASH, 1'b1, 1'b0, 32'd0, ST_OK},
    '{"1",      1'b0, 1'b0, 32'd0, ST_OK},
    '{"2",      1'b1, 1'b0, 32'd0, ST_OK},
    '{"5",      1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_MINUS, 1'b1, 1'b1, 32'd0, ST_UNDERFLOW},
    '{"#",      1'b0, 1'b0, 32'd0, ST_OK},
    '{"3",      1'b0, 1'b0, 32'd0, ST_OK},
    '{"4",      1'b0, 1'b0, 32'd0, ST_OK},
    '{CH_PLUS,  1'b1, 1'b1, 32'd0, ST_UNKNOWN}
  };

  postfix_digit_expression_evaluator #(
    .STACK_DEPTH(MAX_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_symbol (in_symbol),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  // Mostly short idle spells, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(30, 80);
  endfunction

  // Evaluate one character; return the result the expression closes with, if any
  function automatic void evaluate_symbol(input logic [SYM_W-1:0] sym, input logic lst,
                                          output bit emits, output result_t res);
    logic signed [DATA_W-1:0] lhs;
    logic signed [DATA_W-1:0] rhs;
    logic signed [DATA_W-1:0] acc;
    longint                   quo;
    emits      = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    acc        = '0;
    if (pending_error == ST_OK) begin
      if (sym >= CH_ZERO && sym <= CH_NINE) begin
        if (operand_count >= MAX_DEPTH) begin
          pending_error = ST_OVERFLOW;
        end else begin
          operands[operand_count] = DATA_W'(sym - CH_ZERO);
          operand_count++;
        end
      end else if (sym != CH_PLUS && sym != CH_MINUS && sym != CH_STAR && sym != CH_SLASH) begin
        pending_error = ST_UNKNOWN;
      end else if (operand_count < 2) begin
        pending_error = ST_UNDERFLOW;
      end else begin
        rhs = operands[operand_count-1];
        lhs = operands[operand_count-2];
        if (sym == CH_SLASH && rhs == 0) begin
          pending_error = ST_DIVZERO;
        end else begin
          case (sym)
            CH_PLUS:  acc = lhs + rhs;
            CH_MINUS: acc = lhs - rhs;
            CH_STAR:  acc = lhs * rhs;
            default: begin
              // widen so that the most negative value over -1 wraps cleanly
              quo = longint'(lhs) / longint'(rhs);
              acc = quo[DATA_W-1:0];
            end
          endcase
          operands[operand_count-2] = acc;
          operand_count--;
        end
      end
    end
    // Close the expression on the marked character
    if (lst) begin
      emits      = 1'b1;
      res.status = pending_error;
      if (res.status == ST_OK) begin
        if (operand_count == 0) res.status = ST_UNDERFLOW;
        else res.value = operands[operand_count-1];
      end
      if (res.status != ST_OK) res.value = '0;
      operand_count = 0;
      pending_error = ST_OK;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("MISMATCH at %0t: %s got %08h want %08h", $time, what, got, want);
    mismatches++;
  endtask

  // Drive one character and wait for its transfer
  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic lst, input logic typed,
                             input logic [DATA_W-1:0] want_value,
                             input logic [STATUS_W-1:0] want_status);
    int      gap;
    bit      emits;
    result_t res;
    gap = source_calm ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    in_last   <= lst;
    do @(posedge clk); while (!in_ready);
    evaluate_symbol(sym, lst, emits, res);
    if (emits) begin
      if (typed) begin
        res.value  = want_value;
        res.status = want_status;
      end
      pending_results.push_back(res);
    end
    symbols_sent++;
  endtask

  // Hold off the source until every result is out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_expression();
    foreach (expr_syms[i]) begin
      send_symbol(expr_syms[i], i == expr_syms.size() - 1, 1'b0, '0, ST_OK);
    end
    expr_syms.delete();
  endtask

  function automatic logic [SYM_W-1:0] digit_sym(input int n);
    return CH_ZERO + SYM_W'(n);
  endfunction

  function automatic logic [SYM_W-1:0] random_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Characters just outside the accepted sets, or anything at all
  function automatic logic [SYM_W-1:0] noise_sym();
    case ($urandom_range(0, 7))
      0:       return CH_ZERO - 8'd1;
      1:       return CH_NINE + 8'd1;
      2:       return CH_STAR - 8'd1;
      3:       return CH_PLUS + 8'd1;
      4:       return CH_MINUS + 8'd1;
      default: return SYM_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Valid postfix of n operands, optionally leaving extra operands below the top
  task automatic build_well_formed(input int n, input bit keep_extra);
    int depth_now;
    int left;
    depth_now = 0;
    left      = n;
    while (left > 0 || (depth_now > 1 && !keep_extra)) begin
      if (left > 0 && (depth_now < 2 ||
                       (depth_now < MAX_DEPTH && $urandom_range(0, 2) != 0))) begin
        expr_syms.push_back(digit_sym($urandom_range(0, 9)));
        left--;
        depth_now++;
      end else begin
        expr_syms.push_back(random_op());
        depth_now--;
      end
    end
  endtask

  // Build the most negative value, then divide it by -1 (or by 1)
  task automatic build_min_quotient();
    expr_syms.push_back(digit_sym(8));
    repeat (9) begin
      expr_syms.push_back(digit_sym(8));
      expr_syms.push_back(CH_STAR);
    end
    expr_syms.push_back(digit_sym(2));
    expr_syms.push_back(CH_STAR);
    if ($urandom_range(0, 3) != 0) begin
      expr_syms.push_back(digit_sym(0));
      expr_syms.push_back(digit_sym(1));
      expr_syms.push_back(CH_MINUS);
    end else begin
      expr_syms.push_back(digit_sym(1));
    end
    expr_syms.push_back(CH_SLASH);
  endtask

  // Push past the stack depth, then a few operators that get ignored
  task automatic build_overflow();
    repeat (MAX_DEPTH + $urandom_range(1, 3)) expr_syms.push_back(digit_sym($urandom_range(0, 9)));
    repeat ($urandom_range(0, 3)) expr_syms.push_back(random_op());
  endtask

  // Long product chains reach wide, wrapped and negative values
  task automatic build_long_chain();
    expr_syms.push_back(digit_sym($urandom_range(1, 9)));
    repeat ($urandom_range(8, 20)) begin
      expr_syms.push_back(digit_sym($urandom_range(1, 9)));
      case ($urandom_range(0, 4))
        0:       expr_syms.push_back(CH_PLUS);
        1:       expr_syms.push_back(CH_MINUS);
        default: expr_syms.push_back(CH_STAR);
      endcase
    end
  endtask

  // Valid expression with one character corrupted, dropped or an operator up front
  task automatic build_broken();
    int idx;
    build_well_formed($urandom_range(1, 6), 1'b0);
    idx = $urandom_range(0, expr_syms.size() - 1);
    case ($urandom_range(0, 2))
      0: expr_syms[idx] = noise_sym();
      1: expr_syms.push_front(random_op());
      default: if (expr_syms.size() > 1) expr_syms.delete(idx);
    endcase
  endtask

  // Result sink: random stalls, with long stretches of steady ready
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      sink_hold <= idle_len();
    end else begin
      out_ready <= 1'b1;
      sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(0, 15);
    end
  end

  // Check every result transfer against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending, value", out_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value) report_mismatch("value", out_value, want.value);
        if (out_status !== want.status) begin
          report_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
        end
      end
    end
  end

  // Stimulus
  initial begin
    int pick;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_symbol(directed_rows[i].sym, directed_rows[i].last, directed_rows[i].typed,
                  directed_rows[i].value, directed_rows[i].status);
    end
    drain_results();

    build_overflow();
    send_expression();
    build_min_quotient();
    send_expression();

    while (symbols_sent < RANDOM_ITEMS) begin
      source_calm = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        build_well_formed($urandom_range(1, 6), 1'b0);
      end else if (pick < 65) begin
        build_well_formed($urandom_range(7, MAX_DEPTH), $urandom_range(0, 3) == 0);
      end else if (pick < 72) begin
        repeat ($urandom_range(1, 6)) expr_syms.push_back(noise_sym());
      end else if (pick < 82) begin
        build_broken();
      end else if (pick < 87) begin
        build_overflow();
      end else if (pick < 91) begin
        build_min_quotient();
      end else begin
        build_long_chain();
      end
      send_expression();
      if ($urandom_range(0, 39) == 0) drain_results();
    end

    // Let the last results out
    source_calm = 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(20_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hdl/pdee_pkg.sv
hdl/pdee_front.sv
hdl/pdee_queue.sv
hdl/pdee_divider.sv
hdl/pdee_back.sv
hdl/postfix_digit_expression_evaluator.sv
verif/tb.sv
